// ----- design/led_panel_gauge_and_blink_controller_unit_macros.svh -----
// Assertion macros for the LED panel gauge and blink controller.
// Each macro expects clk and rst_n in scope; ASSERT_OFF drops all checks.
`ifndef LED_PANEL_GAUGE_AND_BLINK_CONTROLLER_UNIT_MACROS_SVH
`define LED_PANEL_GAUGE_AND_BLINK_CONTROLLER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define LPGB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define LPGB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LPGB_ASSERT_IMP(label, ante, cons, msg)
`define LPGB_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ----- design/lpgb_pkg.sv -----
// Types, codes and timing constants for the LED panel gauge and blink controller.
// No dependencies; used by the channel interfaces, the render logic and the top level.
package lpgb_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_POWER_ALWAYS_ON   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECO_SHOWS_WIFI    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREVIEW_LINGER_MS = 2'd2;

    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_UPDATE  = 3'd1,
        ACT_PRESS   = 3'd2,
        ACT_RELEASE = 3'd3,
        ACT_MODE    = 3'd4,
        ACT_AP      = 3'd5
    } action_t;

    localparam int NUM_MARKS          = 5;
    localparam int BLINK_PERIOD_MS    = 1000;
    localparam int BLINK_ON_MS        = 500;
    localparam int MODE_BLANK_MS      = 500;
    localparam int MODE_ON_MS         = 280;
    localparam int MODE_OFF_MS        = 220;
    localparam int MODE_PERIOD_MS     = MODE_ON_MS + MODE_OFF_MS;
    localparam int AP_ON_MS           = 120;
    localparam int AP_OFF_MS          = 120;
    localparam int AP_PERIOD_MS       = AP_ON_MS + AP_OFF_MS;
    localparam int AP_BLINKS          = 6;
    localparam int LINGER_DEFAULT_MS  = 3000;
    localparam int HALF_STEP_TENTHS   = 50;

    localparam logic [7:0] GAUGE_MARKS [NUM_MARKS] = '{8'd40, 8'd50, 8'd60, 8'd70, 8'd80};

    // lower edge of each mark in tenths of a degree
    function automatic logic signed [11:0] gauge_thresh(input int i);
        return 12'(int'(GAUGE_MARKS[i]) * 10 - HALF_STEP_TENTHS);
    endfunction

    typedef struct packed {
        logic [2:0]         action;
        logic signed [11:0] temp_tenths;
        logic               temp_valid;
        logic               master_on;
        logic               heating_any;
        logic               heating_single;
        logic               hot_water_ready;
        logic               link_up;
        logic [7:0]         preview_degrees;
        logic [7:0]         mode_number;
    } in_item_t;

    typedef struct packed {
        logic [4:0] gauge_leds;
        logic       power_led;
        logic       eco_led;
        logic       shower_led;
    } out_item_t;

    typedef struct packed {
        logic        power_always_on;
        logic        eco_shows_wifi;
        logic [15:0] preview_linger_ms;
    } cfg_t;

    // flags: bit0 master, bit1 any heating, bit2 single, bit3 hot water, bit4 link
    typedef struct packed {
        logic signed [11:0] temp;
        logic               temp_ok;
        logic [4:0]         flags;
        logic [7:0]         prev_val;
        logic               prev_down;
        logic [15:0]        prev_left;
        logic [9:0]         blink_ms;
        logic               mode_run;
        logic               mode_blank;
        logic [8:0]         mode_pos;
        logic [7:0]         mode_idx;
        logic [7:0]         mode_total;
        logic               ap_run;
        logic [7:0]         ap_pos;
        logic [2:0]         ap_idx;
    } state_t;

    typedef struct packed {
        logic prev_clear;
        logic mode_end;
        logic ap_end;
    } render_clr_t;

endpackage

// ----- design/lpgb_in_if.sv -----
// Input item channel: valid/ready handshake with an in_item_t payload.
// Depends on lpgb_pkg.
interface lpgb_in_if;
    import lpgb_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ----- design/lpgb_out_if.sv -----
// Result item channel: valid/ready handshake with an out_item_t payload.
// Depends on lpgb_pkg.
interface lpgb_out_if;
    import lpgb_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ----- design/led_panel_gauge_and_blink_controller_unit.sv -----
// LED panel gauge and blink controller, top level.
// Depends on lpgb_pkg, lpgb_in_if, lpgb_out_if, lpgb_render and the macro header.
//
// Usage:
//   in_ch carries one action item (tick, state update, preview press/release,
//   mode or AP animation start); out_ch returns one LED result item per input.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
//   it only while no item is in flight.
//   Results are registered: in the output register, or in the skid entry.
//   Throughput: one item per cycle unless in_ch.ready is low; the update and
//   render are combinational between state registers and output register.
//   Stall: a two-entry output (register plus skid) lets one more item enter
//   while a result waits; in_ch.ready drops only while the skid entry is full.
//   Reset: all state clears, the registers take their reset values
//   (preview linger 3000 ms), and both channels come up empty.
//   Animation timing runs from tick items only: the mode animation is 500 ms
//   dark then mode_number+1 blinks (8-bit sum, 255 gives none) of 280/220
//   ms; the AP animation blinks ECO six times at 120/120 ms.
module led_panel_gauge_and_blink_controller_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lpgb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpgb_pkg::CFG_DATA_W-1:0] cfg_data,
    lpgb_in_if.sink                        in_ch,
    lpgb_out_if.source                     out_ch
);
    import lpgb_pkg::*;

`include "led_panel_gauge_and_blink_controller_unit_macros.svh"

    cfg_t        cfg_reg;
    state_t      st_reg;
    state_t      st_upd;
    state_t      st_next;
    out_item_t   result;
    render_clr_t clr;

    logic        out_valid_reg;
    out_item_t   out_item_reg;
    logic        skid_valid_reg;
    out_item_t   skid_item_reg;
    logic        accept;
    logic        out_take;

    assign in_ch.ready  = !skid_valid_reg;
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_take     = out_valid_reg && out_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.item  = out_item_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_always_on   <= 1'b0;
            cfg_reg.eco_shows_wifi    <= 1'b0;
            cfg_reg.preview_linger_ms <= 16'(LINGER_DEFAULT_MS);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POWER_ALWAYS_ON:   cfg_reg.power_always_on   <= cfg_data[0];
                CFG_ECO_SHOWS_WIFI:    cfg_reg.eco_shows_wifi    <= cfg_data[0];
                CFG_PREVIEW_LINGER_MS: cfg_reg.preview_linger_ms <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // apply the item's action
    always_comb
    begin
        st_upd = st_reg;
        case (in_ch.item.action)
            ACT_TICK:
            begin
                st_upd.blink_ms = (st_reg.blink_ms == 10'(BLINK_PERIOD_MS - 1)) ? 10'd0
                                  : st_reg.blink_ms + 10'd1;
                if (st_reg.prev_left != 16'd0)
                begin
                    st_upd.prev_left = st_reg.prev_left - 16'd1;
                end
                if (st_reg.mode_run)
                begin
                    if (st_reg.mode_blank && st_reg.mode_pos == 9'(MODE_BLANK_MS - 1))
                    begin
                        st_upd.mode_pos   = 9'd0;
                        st_upd.mode_blank = 1'b0;
                    end
                    else if (!st_reg.mode_blank
                             && st_reg.mode_pos == 9'(MODE_PERIOD_MS - 1))
                    begin
                        st_upd.mode_pos = 9'd0;
                        if (st_reg.mode_idx != 8'hFF)
                        begin
                            st_upd.mode_idx = st_reg.mode_idx + 8'd1;
                        end
                    end
                    else
                    begin
                        st_upd.mode_pos = st_reg.mode_pos + 9'd1;
                    end
                end
                if (st_reg.ap_run)
                begin
                    if (st_reg.ap_pos == 8'(AP_PERIOD_MS - 1))
                    begin
                        st_upd.ap_pos = 8'd0;
                        if (st_reg.ap_idx != 3'(AP_BLINKS))
                        begin
                            st_upd.ap_idx = st_reg.ap_idx + 3'd1;
                        end
                    end
                    else
                    begin
                        st_upd.ap_pos = st_reg.ap_pos + 8'd1;
                    end
                end
            end
            ACT_UPDATE:
            begin
                st_upd.temp    = in_ch.item.temp_tenths;
                st_upd.temp_ok = in_ch.item.temp_valid;
                st_upd.flags   = {in_ch.item.link_up, in_ch.item.hot_water_ready,
                                  in_ch.item.heating_single, in_ch.item.heating_any,
                                  in_ch.item.master_on};
            end
            ACT_PRESS:
            begin
                st_upd.prev_val  = in_ch.item.preview_degrees;
                st_upd.prev_down = 1'b1;
            end
            ACT_RELEASE:
            begin
                st_upd.prev_down = 1'b0;
                st_upd.prev_left = (cfg_reg.preview_linger_ms != 16'd0)
                                   ? cfg_reg.preview_linger_ms : 16'(LINGER_DEFAULT_MS);
            end
            ACT_MODE:
            begin
                st_upd.mode_run   = 1'b1;
                st_upd.mode_blank = 1'b1;
                st_upd.mode_pos   = 9'd0;
                st_upd.mode_idx   = 8'd0;
                st_upd.mode_total = in_ch.item.mode_number + 8'd1;
            end
            ACT_AP:
            begin
                st_upd.ap_run = 1'b1;
                st_upd.ap_pos = 8'd0;
                st_upd.ap_idx = 3'd0;
            end
            default: ;
        endcase
    end

    lpgb_render u_render (
        .cfg  (cfg_reg),
        .st   (st_upd),
        .leds (result),
        .clr  (clr)
    );

    // drop whatever the render found finished
    always_comb
    begin
        st_next = st_upd;
        if (clr.prev_clear)
        begin
            st_next.prev_val = 8'd0;
        end
        if (clr.mode_end)
        begin
            st_next.mode_run = 1'b0;
        end
        if (clr.ap_end)
        begin
            st_next.ap_run = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (accept)
        begin
            st_reg <= st_next;
        end
    end

    // output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_reg <= accept;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && skid_valid_reg)
        begin
            out_item_reg <= skid_item_reg;
        end
        else if (accept && (out_take || !out_valid_reg))
        begin
            out_item_reg <= result;
        end
        if (accept && out_valid_reg && !out_take)
        begin
            skid_item_reg <= result;
        end
    end

    `LPGB_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg,
                     "skid entry held with empty output register")
    `LPGB_ASSERT_IMP(a_mode_idx_bound, st_reg.mode_run, st_reg.mode_idx <= st_reg.mode_total,
                     "mode blink index past its total while running")
    `LPGB_ASSERT_IMP(a_ap_idx_bound, st_reg.ap_run, st_reg.ap_idx < 3'(AP_BLINKS),
                     "AP blink index past its end while running")
    `LPGB_ASSERT_NXT(a_mode_start, accept && in_ch.item.action == ACT_MODE,
                     st_reg.mode_run && st_reg.mode_blank,
                     "mode animation did not start in its dark phase")

endmodule

// ----- design/lpgb_render.sv -----
// Panel render: gauge, status LEDs and animation overrides from the updated state.
// Depends on lpgb_pkg; also reports which pieces of state end at this render.
module lpgb_render (
    input  lpgb_pkg::cfg_t        cfg,
    input  lpgb_pkg::state_t      st,
    output lpgb_pkg::out_item_t   leds,
    output lpgb_pkg::render_clr_t clr
);
    import lpgb_pkg::*;

    logic [NUM_MARKS-1:0] ge;
    logic [NUM_MARKS-1:0] chain;
    logic [NUM_MARKS-1:0] next_mark;
    logic [NUM_MARKS-1:0] prev_hit;
    logic                 master;
    logic                 prev_active;
    logic                 blink_on;

    always_comb
    begin
        for (int i = 0; i < NUM_MARKS; i++)
        begin
            ge[i]       = st.temp >= gauge_thresh(i);
            prev_hit[i] = GAUGE_MARKS[i] == st.prev_val;
        end
        // lit run from the bottom mark; the first gap is the next mark
        chain[0]     = ge[0];
        next_mark[0] = !ge[0];
        for (int i = 1; i < NUM_MARKS; i++)
        begin
            chain[i]     = chain[i-1] && ge[i];
            next_mark[i] = chain[i-1] && !ge[i];
        end
    end

    assign master      = st.flags[0];
    assign prev_active = (st.prev_val != 8'd0) && (st.prev_down || (st.prev_left != 16'd0));
    assign blink_on    = st.flags[1] && (st.blink_ms < 10'(BLINK_ON_MS));

    always_comb
    begin
        leds = '0;
        clr  = '0;

        if (prev_active)
        begin
            leds.gauge_leds = prev_hit;
        end
        else
        begin
            clr.prev_clear = st.prev_val != 8'd0;
            if (master && st.temp_ok)
            begin
                leds.gauge_leds = chain | (blink_on ? next_mark : '0);
            end
        end

        leds.power_led  = master && (cfg.power_always_on || st.flags[1]);
        leds.shower_led = master && st.flags[3];
        leds.eco_led    = cfg.eco_shows_wifi ? st.flags[4] : (master && st.flags[2]);

        if (st.ap_run)
        begin
            if (st.ap_idx >= 3'(AP_BLINKS))
            begin
                clr.ap_end = 1'b1;
            end
            else
            begin
                leds.eco_led = st.ap_pos < 8'(AP_ON_MS);
            end
        end

        if (st.mode_run)
        begin
            if (st.mode_blank)
            begin
                leds.power_led  = 1'b0;
                leds.eco_led    = 1'b0;
                leds.shower_led = 1'b0;
            end
            else if (st.mode_idx >= st.mode_total)
            begin
                clr.mode_end = 1'b1;
            end
            else
            begin
                leds.power_led  = st.mode_pos < 9'(MODE_ON_MS);
                leds.eco_led    = st.mode_pos < 9'(MODE_ON_MS);
                leds.shower_led = st.mode_pos < 9'(MODE_ON_MS);
            end
        end
    end

endmodule

// ----- tb/sv/led_panel_gauge_and_blink_controller_unit_tb.sv -----
// Self-checking bench for the LED panel gauge and blink controller: an LED pattern
// tracker predicts every result item, random idling on both channels exercises stalls.
// Depends on lpgb_pkg, lpgb_in_if, lpgb_out_if and the controller top level.
module led_panel_gauge_and_blink_controller_unit_tb;
    import lpgb_pkg::*;

    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    localparam int F_MASTER = 0;
    localparam int F_ANY = 1;
    localparam int F_SINGLE = 2;
    localparam int F_SHOWER = 3;
    localparam int F_LINK = 4;
    localparam int MODE_MS_MAX = 131071;
    localparam int AP_MS_MAX = 2047;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 190;

    class led_panel_tracker;
        bit                 pwr_always;
        bit                 eco_wifi;
        logic [15:0]        hold_ms;
        logic signed [11:0] temp;
        bit                 temp_ok;
        logic [4:0]         flags;
        logic [7:0]         pv_val;
        bit                 pv_down;
        logic [15:0]        pv_left;
        int                 blink_ms;
        bit                 mode_run;
        int                 mode_ms;
        logic [7:0]         mode_total;
        bit                 ap_run;
        int                 ap_ms;
        out_item_t          pending_leds[$];
        int                 checked;
        int                 led_errors;

        function new();
            pwr_always = 1'b0;
            eco_wifi = 1'b0;
            hold_ms = 16'(LINGER_DEFAULT_MS);
            temp = '0;
            temp_ok = 1'b0;
            flags = '0;
            pv_val = '0;
            pv_down = 1'b0;
            pv_left = '0;
            blink_ms = 0;
            mode_run = 1'b0;
            mode_ms = 0;
            mode_total = '0;
            ap_run = 1'b0;
            ap_ms = 0;
            checked = 0;
            led_errors = 0;
        endfunction

        function void apply_settings(bit pwr, bit eco, logic [15:0] linger);
            pwr_always = pwr;
            eco_wifi = eco;
            hold_ms = linger;
        endfunction

        // Render clears expired previews and finished animations as a side effect.
        function out_item_t render_panel();
            out_item_t r;
            bit        pv_active;
            bit        master;
            bit        pwr;
            bit        eco;
            bit        shw;
            bit        lit;
            bit        stop;
            int        nxt;
            int        into;
            r = '0;
            pv_active = 1'b0;
            master = flags[F_MASTER];
            if (pv_val != 0) begin
                if (pv_down || pv_left != 0) begin
                    pv_active = 1'b1;
                    for (int i = 0; i < NUM_MARKS; i++)
                        if (GAUGE_MARKS[i] == pv_val) r.gauge_leds[i] = 1'b1;
                end else begin
                    pv_val = '0;
                end
            end
            if (!pv_active && master && temp_ok) begin
                nxt = -1;
                stop = 1'b0;
                for (int i = 0; i < NUM_MARKS; i++) begin
                    if (!stop) begin
                        if (int'(temp) >= int'(GAUGE_MARKS[i]) * 10 - HALF_STEP_TENTHS) begin
                            r.gauge_leds[i] = 1'b1;
                        end else begin
                            nxt = i;
                            stop = 1'b1;
                        end
                    end
                end
                if (nxt >= 0 && flags[F_ANY] && blink_ms < BLINK_ON_MS)
                    r.gauge_leds[nxt] = 1'b1;
            end
            pwr = master && (pwr_always || flags[F_ANY]);
            shw = master && flags[F_SHOWER];
            eco = eco_wifi ? flags[F_LINK] : (master && flags[F_SINGLE]);
            if (ap_run) begin
                if (ap_ms / AP_PERIOD_MS >= AP_BLINKS) ap_run = 1'b0;
                else eco = (ap_ms % AP_PERIOD_MS) < AP_ON_MS;
            end
            if (mode_run) begin
                if (mode_ms < MODE_BLANK_MS) begin
                    pwr = 1'b0;
                    eco = 1'b0;
                    shw = 1'b0;
                end else begin
                    into = mode_ms - MODE_BLANK_MS;
                    if (into / MODE_PERIOD_MS >= int'(mode_total)) begin
                        mode_run = 1'b0;
                    end else begin
                        lit = (into % MODE_PERIOD_MS) < MODE_ON_MS;
                        pwr = lit;
                        eco = lit;
                        shw = lit;
                    end
                end
            end
            r.power_led = pwr;
            r.eco_led = eco;
            r.shower_led = shw;
            return r;
        endfunction

        function void take_action(in_item_t it);
            case (it.action)
                ACT_TICK: begin
                    blink_ms = (blink_ms + 1) % BLINK_PERIOD_MS;
                    if (pv_left != 0) pv_left = pv_left - 16'd1;
                    if (mode_run && mode_ms < MODE_MS_MAX) mode_ms++;
                    if (ap_run && ap_ms < AP_MS_MAX) ap_ms++;
                end
                ACT_UPDATE: begin
                    temp = it.temp_tenths;
                    temp_ok = it.temp_valid;
                    flags = {it.link_up, it.hot_water_ready, it.heating_single,
                             it.heating_any, it.master_on};
                end
                ACT_PRESS: begin
                    pv_val = it.preview_degrees;
                    pv_down = 1'b1;
                end
                ACT_RELEASE: begin
                    pv_down = 1'b0;
                    pv_left = (hold_ms != 0) ? hold_ms : 16'(LINGER_DEFAULT_MS);
                end
                ACT_MODE: begin
                    mode_run = 1'b1;
                    mode_ms = 0;
                    mode_total = it.mode_number + 8'd1;
                end
                ACT_AP: begin
                    ap_run = 1'b1;
                    ap_ms = 0;
                end
                default: ;
            endcase
            pending_leds.push_back(render_panel());
        endfunction

        task flag_mismatch(string what, int want, int got);
            $display("mismatch on result %0d: %s expected %0h got %0h",
                     checked, what, want, got);
            led_errors++;
        endtask

        task compare_leds(out_item_t got);
            out_item_t want;
            if (pending_leds.size() == 0) begin
                flag_mismatch("result with no item pending", 0, int'(got));
            end else begin
                want = pending_leds.pop_front();
                if (got.gauge_leds !== want.gauge_leds)
                    flag_mismatch("gauge_leds", int'(want.gauge_leds), int'(got.gauge_leds));
                if (got.power_led !== want.power_led)
                    flag_mismatch("power_led", int'(want.power_led), int'(got.power_led));
                if (got.eco_led !== want.eco_led)
                    flag_mismatch("eco_led", int'(want.eco_led), int'(got.eco_led));
                if (got.shower_led !== want.shower_led)
                    flag_mismatch("shower_led", int'(want.shower_led), int'(got.shower_led));
            end
            checked++;
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lpgb_in_if  in_ch();
    lpgb_out_if out_ch();

    led_panel_tracker panel;
    int               send_calm;
    int               recv_calm;
    int               idle_cycles = 0;
    int               ms_since_mode;
    int               ms_since_ap;

    led_panel_gauge_and_blink_controller_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    always #6 clk = ~clk;

    // Zero while in a calm stretch, which can also start here; otherwise a random wait.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(24) == 0) begin
            calm = $urandom_range(40, 10);
            return 0;
        end
        return $urandom_range(11);
    endfunction

    function automatic logic signed [11:0] pick_temp();
        case ($urandom_range(9))
            0, 1: return 12'($urandom);
            8: return 12'(int'($urandom_range(3000)) - 1000);
            9: return $urandom_range(1) ? 12'sh7FF : 12'sh800;
            // land on or next to a mark's lower edge
            default: return 12'(400 + 100 * int'($urandom_range(4)) - HALF_STEP_TENTHS
                                + int'($urandom_range(2)) - 1);
        endcase
    endfunction

    function automatic logic [7:0] pick_preview();
        case ($urandom_range(9))
            0, 1: return 8'd0;
            2, 3, 4: return 8'($urandom);
            default: return GAUGE_MARKS[$urandom_range(NUM_MARKS - 1)];
        endcase
    endfunction

    function automatic logic [7:0] pick_mode();
        case ($urandom_range(9))
            0, 1: return 8'd1;
            2: return 8'd255;
            3: return 8'($urandom);
            default: return 8'd0;
        endcase
    endfunction

    function automatic in_item_t fresh_item(input logic [2:0] act);
        in_item_t it;
        it.action = act;
        it.temp_tenths = pick_temp();
        it.temp_valid = $urandom_range(6) != 0;
        it.master_on = $urandom_range(4) != 0;
        it.heating_any = $urandom_range(2) != 0;
        it.heating_single = 1'($urandom_range(1));
        it.hot_water_ready = 1'($urandom_range(1));
        it.link_up = 1'($urandom_range(1));
        it.preview_degrees = pick_preview();
        it.mode_number = pick_mode();
        return it;
    endfunction

    // f: bit0 master, bit1 any heating, bit2 single, bit3 hot water, bit4 link
    function automatic in_item_t state_item(input int t, input bit ok, input logic [4:0] f);
        in_item_t it;
        it = fresh_item(ACT_UPDATE);
        it.temp_tenths = 12'(t);
        it.temp_valid = ok;
        {it.link_up, it.hot_water_ready, it.heating_single, it.heating_any, it.master_on} = f;
        return it;
    endfunction

    // Mostly ticks; a mode start needs 700 ticks since the last one and an AP start 400, else a tick goes instead.
    function automatic in_item_t random_item();
        int       r;
        logic [2:0] act;
        r = $urandom_range(99);
        if (r < 80) act = ACT_TICK;
        else if (r < 88) act = ACT_UPDATE;
        else if (r < 92) act = ACT_PRESS;
        else if (r < 95) act = ACT_RELEASE;
        else if (r < 97) act = (ms_since_mode >= 700) ? ACT_MODE : ACT_TICK;
        else if (r < 99) act = (ms_since_ap >= 400) ? ACT_AP : ACT_TICK;
        else act = $urandom_range(1) ? ACT_SPARE_6 : ACT_SPARE_7;
        if (act == ACT_TICK) begin
            ms_since_mode++;
            ms_since_ap++;
        end
        if (act == ACT_MODE) ms_since_mode = 0;
        if (act == ACT_AP) ms_since_ap = 0;
        return fresh_item(act);
    endfunction

    // Valid stays high after acceptance; the next call lowers it only for a gap.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.item <= it;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic take_results();
        int stall;
        bit held;
        held = 1'b0;
        forever begin
            stall = draw_wait(recv_calm);
            // one long hold-off so the skid fills and the input stalls
            if (!held && panel.checked >= 200) begin
                stall = 120;
                held = 1'b1;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (panel.pending_leds.size() != 0) @(posedge clk);
    endtask

    task automatic load_settings(input bit pwr, input bit eco, input logic [15:0] linger);
        cfg_we <= 1'b1;
        cfg_index <= CFG_POWER_ALWAYS_ON;
        cfg_data <= CFG_DATA_W'(pwr);
        @(posedge clk);
        cfg_index <= CFG_ECO_SHOWS_WIFI;
        cfg_data <= CFG_DATA_W'(eco);
        @(posedge clk);
        cfg_index <= CFG_PREVIEW_LINGER_MS;
        cfg_data <= linger;
        @(posedge clk);
        cfg_we <= 1'b0;
        panel.apply_settings(pwr, eco, linger);
    endtask

    task automatic run_phase(input bit pwr, input bit eco, input logic [15:0] linger);
        load_settings(pwr, eco, linger);
        for (int n = 0; n < PHASE_ITEMS; n++)
            send_item(random_item());
        drain();
    endtask

    task automatic run_directed();
        in_item_t it;
        send_item(state_item(2047, 1'b1, 5'b11111));
        send_item(state_item(-2048, 1'b1, 5'b11111));
        send_item(state_item(350, 1'b1, 5'b00011));
        send_item(state_item(349, 1'b1, 5'b00011));
        send_item(state_item(750, 1'b1, 5'b00011));
        send_item(state_item(600, 1'b0, 5'b11111));
        send_item(state_item(600, 1'b1, 5'b11110));
        send_item(state_item(649, 1'b1, 5'b11111));
        it = fresh_item(ACT_PRESS);
        it.preview_degrees = 8'd60;
        send_item(it);
        // preview off the marks still blanks the gauge
        it = fresh_item(ACT_PRESS);
        it.preview_degrees = 8'd65;
        send_item(it);
        send_item(fresh_item(ACT_RELEASE));
        send_item(fresh_item(ACT_TICK));
        it = fresh_item(ACT_PRESS);
        it.preview_degrees = 8'd0;
        send_item(it);
        it = fresh_item(ACT_PRESS);
        it.preview_degrees = 8'd255;
        send_item(it);
        send_item(fresh_item(ACT_RELEASE));
        // blink count wraps to zero
        it = fresh_item(ACT_MODE);
        it.mode_number = 8'd255;
        send_item(it);
        send_item(fresh_item(ACT_TICK));
        send_item(fresh_item(ACT_AP));
        send_item(fresh_item(ACT_TICK));
        it = fresh_item(ACT_MODE);
        it.mode_number = 8'd3;
        send_item(it);
        send_item(fresh_item(ACT_AP));
        send_item(fresh_item(ACT_SPARE_6));
        send_item(fresh_item(ACT_SPARE_7));
        send_item(fresh_item(ACT_TICK));
        drain();
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) panel.compare_leds(out_ch.item);
            if (in_ch.valid && in_ch.ready) panel.take_action(in_ch.item);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        panel = new();
        send_calm = 0;
        recv_calm = 0;
        ms_since_mode = 700;
        ms_since_ap = 400;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.item <= '0;
        out_ch.ready <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            take_results();
        join_none
        run_directed();
        run_phase(1'b1, 1'b0, 16'd0);
        run_phase(1'b0, 1'b1, 16'd1);
        run_phase(1'b1, 1'b1, 16'hFFFF);
        run_phase(1'b0, 1'b0, 16'd20);
        run_phase(1'b0, 1'b1, 16'd3000);
        repeat (4) @(posedge clk);
        if (panel.led_errors == 0 && panel.pending_leds.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
